// ===== rtl/spm_pkg.sv =====
// Shared types, constants and register map of the substring and prefix matcher.
`default_nettype none

package spm_pkg;

    // Default sizing, overridable on the top level
    localparam int MAX_QUERY_DEF = 16;
    localparam int MAX_ENTRY_DEF = 4096;

    // Fixed field widths
    localparam int POS_W       = 13;
    localparam int QLEN_W      = 5;
    localparam int QUERY_BYTES = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int PADDR_W     = 6;
    localparam int REG_IDX_W   = 3;

    // Register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_QUERY_LO  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_QUERY_HI  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_QUERY_LEN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RNG   = 3'd4;

    localparam logic [7:0] MAX_RANGES_RST = 8'd16;

    // Result kinds and search modes
    localparam logic KIND_RANGE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;
    localparam logic MODE_LINE    = 1'b0;
    localparam logic MODE_PREFIX  = 1'b1;

    // Output queue sizing
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    typedef struct packed {
        logic [7:0] entry_byte;
        logic       end_of_entry;
        logic       entry_empty;
    } t_in_beat;

    typedef struct packed {
        logic             result_kind;
        logic [POS_W-1:0] range_start;
        logic [POS_W-1:0] range_end;
        logic             entry_matched;
        logic             last_of_run;
    } t_out_beat;

    // Live configuration handed to the match core
    typedef struct packed {
        logic [63:0]       query_bytes_high;
        logic [63:0]       query_bytes_low;
        logic [QLEN_W-1:0] query_length;
        logic              search_mode;
        logic [7:0]        range_cap;
    } t_cfg;

    // Up to two result beats per processed byte, first one first
    typedef struct packed {
        logic      v0;
        logic      v1;
        t_out_beat beat0;
        t_out_beat beat1;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/substring_and_prefix_matcher.sv =====
// Top level: an accepted input beat is held in the input register, then written into the result queue,
// from which the output reads. Throughput: one input beat per cycle while the result queue has room; a byte
// that yields a range and a verdict puts two beats into the 4-entry result queue, which sets the sustained rate.
// The input register holds a beat while the result queue lacks room for two beats.
// Reset (synchronous, active low) clears config to defaults, the entry state and the queue.
`default_nettype none

module substring_and_prefix_matcher #(
    parameter int MAX_QUERY = spm_pkg::MAX_QUERY_DEF,
    parameter int MAX_ENTRY = spm_pkg::MAX_ENTRY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input beats
    input  wire logic                           i_in_valid,
    input  wire spm_pkg::t_in_beat              i_in_data,
    output logic                                o_in_ready,
    // Result beats
    output logic                                o_out_valid,
    output spm_pkg::t_out_beat                  o_out_data,
    input  wire logic                           i_out_ready,
    // Configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [spm_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [spm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [spm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);

    spm_pkg::t_cfg  w_cfg;
    spm_pkg::t_push w_push;
    logic           w_room;

    spm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    spm_core #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_ENTRY (MAX_ENTRY)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_room     (w_room),
        .o_push     (w_push)
    );

    spm_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/spm_cfg.sv =====
// APB-style configuration register file of the matcher.
`default_nettype none

module spm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [spm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [spm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    output spm_pkg::t_cfg                      o_cfg
);

    logic [63:0]                  r_qlo;
    logic [63:0]                  r_qhi;
    logic [spm_pkg::QLEN_W-1:0]   r_qlen;
    logic                         r_mode;
    logic [7:0]                   r_max_rng;
    logic [spm_pkg::REG_IDX_W-1:0] c_idx;
    logic                         c_wr;

    assign pready = 1'b1;
    assign c_idx  = paddr[spm_pkg::PADDR_W-1:3];
    assign c_wr   = psel && penable && pwrite;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlo     <= '0;
            r_qhi     <= '0;
            r_qlen    <= '0;
            r_mode    <= spm_pkg::MODE_LINE;
            r_max_rng <= spm_pkg::MAX_RANGES_RST;
        end else if (c_wr) begin
            case (c_idx)
                spm_pkg::REG_QUERY_LO:  r_qlo     <= pwdata;
                spm_pkg::REG_QUERY_HI:  r_qhi     <= pwdata;
                spm_pkg::REG_QUERY_LEN: r_qlen    <= pwdata[spm_pkg::QLEN_W-1:0];
                spm_pkg::REG_MODE:      r_mode    <= pwdata[0];
                spm_pkg::REG_MAX_RNG:   r_max_rng <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        case (c_idx)
            spm_pkg::REG_QUERY_LO:  prdata = r_qlo;
            spm_pkg::REG_QUERY_HI:  prdata = r_qhi;
            spm_pkg::REG_QUERY_LEN: prdata = spm_pkg::CFG_DATA_W'(r_qlen);
            spm_pkg::REG_MODE:      prdata = spm_pkg::CFG_DATA_W'(r_mode);
            spm_pkg::REG_MAX_RNG:   prdata = spm_pkg::CFG_DATA_W'(r_max_rng);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.query_bytes_low  = r_qlo;
    assign o_cfg.query_bytes_high = r_qhi;
    assign o_cfg.query_length     = r_qlen;
    assign o_cfg.search_mode      = r_mode;
    assign o_cfg.range_cap        = r_max_rng;

endmodule

`default_nettype wire

// ===== rtl/spm_core.sv =====
// Input register, per-entry match state and the combinational window compare.
`default_nettype none

module spm_core #(
    parameter int MAX_QUERY = spm_pkg::MAX_QUERY_DEF,
    parameter int MAX_ENTRY = spm_pkg::MAX_ENTRY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spm_pkg::t_cfg     i_cfg,
    input  wire logic              i_in_valid,
    input  wire spm_pkg::t_in_beat i_in_data,
    output logic                   o_in_ready,
    input  wire logic              i_room,
    output spm_pkg::t_push         o_push
);

    // Position width holds MAX_ENTRY + 1 (the "no more starts" mark)
    localparam int PW = $clog2(MAX_ENTRY + 2);
    localparam logic [PW-1:0] ENTRY_LIM = PW'(MAX_ENTRY);
    localparam logic [PW-1:0] NAS_BLOCK = PW'(MAX_ENTRY + 1);
    localparam logic [spm_pkg::QLEN_W-1:0] QMAX = spm_pkg::QLEN_W'(MAX_QUERY);

    // Input register
    logic              r_in_valid;
    spm_pkg::t_in_beat r_in;

    // Per-entry state
    logic [7:0]    r_recent [MAX_QUERY];
    logic [7:0]    n_recent [MAX_QUERY];
    logic [PW-1:0] r_pos,    n_pos;
    logic [PW-1:0] r_nas,    n_nas;
    logic [7:0]    r_ranges, n_ranges;
    logic          r_found,  n_found;
    logic          r_pse,    n_pse;

    logic                        c_fire;
    logic [spm_pkg::QLEN_W-1:0]  c_len;
    logic [PW-1:0]               c_len_p;
    logic [7:0]                  c_q   [spm_pkg::QUERY_BYTES];
    logic [7:0]                  c_win [MAX_QUERY];
    logic [127:0]                c_qall;
    logic                        c_active;
    logic [PW-1:0]               c_pos1;
    logic [PW-1:0]               c_start;
    logic                        c_pse_new;
    logic                        c_same;
    logic [spm_pkg::QLEN_W-1:0]  c_idx;
    logic [7:0]                  c_sel;
    logic                        c_line_hit;
    logic                        c_pfx_hit;
    logic                        c_hit;
    logic                        c_emit;
    logic                        c_verdict;
    spm_pkg::t_out_beat          c_rng_beat;
    spm_pkg::t_out_beat          c_ver_beat;

    assign c_fire     = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || c_fire;

    // Input register: takes a beat when empty or whenever the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Effective query length and query bytes
    assign c_len   = (i_cfg.query_length > QMAX) ? QMAX : i_cfg.query_length;
    assign c_len_p = PW'(c_len);
    assign c_qall  = {i_cfg.query_bytes_high, i_cfg.query_bytes_low};

    always_comb begin
        for (int k = 0; k < spm_pkg::QUERY_BYTES; k++) begin
            c_q[k] = c_qall[8*k +: 8];
        end
    end

    // Window after this byte shifts in, newest first
    always_comb begin
        c_win[0] = r_in.entry_byte;
        for (int k = 1; k < MAX_QUERY; k++) begin
            c_win[k] = r_recent[k-1];
        end
    end

    assign c_active = c_fire && !r_in.entry_empty && (r_pos < ENTRY_LIM);
    assign c_pos1   = r_pos + PW'(1);
    assign c_start  = c_pos1 - c_len_p;

    // Prefix tracking against the query byte at this position
    assign c_pse_new = r_pse && !((r_pos < c_len_p) &&
                                  (r_in.entry_byte != c_q[r_pos[3:0]]));

    // Window compare: query byte i lines up with window slot len-1-i
    always_comb begin
        c_same = 1'b1;
        c_idx  = '0;
        c_sel  = '0;
        for (int i = 0; i < MAX_QUERY; i++) begin
            c_idx = c_len - spm_pkg::QLEN_W'(1) - spm_pkg::QLEN_W'(i);
            c_sel = '0;
            for (int k = 0; k < MAX_QUERY; k++) begin
                if (c_idx == spm_pkg::QLEN_W'(k)) begin
                    c_sel = c_win[k];
                end
            end
            if ((spm_pkg::QLEN_W'(i) < c_len) && (c_sel != c_q[i])) begin
                c_same = 1'b0;
            end
        end
    end

    assign c_line_hit = c_active && (c_len != '0) &&
                        (i_cfg.search_mode == spm_pkg::MODE_LINE) &&
                        (c_pos1 >= c_len_p) && c_same && (c_start >= r_nas);
    assign c_pfx_hit  = c_active && (c_len != '0) &&
                        (i_cfg.search_mode == spm_pkg::MODE_PREFIX) &&
                        (c_pos1 == c_len_p) && c_pse_new;
    assign c_hit      = c_line_hit || c_pfx_hit;
    assign c_emit     = c_hit && (r_ranges < i_cfg.range_cap);
    assign c_verdict  = c_fire && (r_in.entry_empty || r_in.end_of_entry);

    // Result beats
    always_comb begin
        c_rng_beat.result_kind   = spm_pkg::KIND_RANGE;
        c_rng_beat.range_start   = c_line_hit ? spm_pkg::POS_W'(c_start) : '0;
        c_rng_beat.range_end     = c_line_hit ? spm_pkg::POS_W'(c_pos1)
                                              : spm_pkg::POS_W'(c_len);
        c_rng_beat.entry_matched = 1'b0;
        c_rng_beat.last_of_run   = !c_verdict;

        c_ver_beat.result_kind   = spm_pkg::KIND_VERDICT;
        c_ver_beat.range_start   = '0;
        c_ver_beat.range_end     = '0;
        c_ver_beat.entry_matched = (c_len == '0) || r_found || c_hit;
        c_ver_beat.last_of_run   = 1'b1;
    end

    assign o_push.v0    = c_emit || c_verdict;
    assign o_push.v1    = c_emit && c_verdict;
    assign o_push.beat0 = c_emit ? c_rng_beat : c_ver_beat;
    assign o_push.beat1 = c_ver_beat;

    // Next state
    always_comb begin
        n_recent = r_recent;
        n_pos    = r_pos;
        n_nas    = r_nas;
        n_ranges = r_ranges;
        n_found  = r_found;
        n_pse    = r_pse;
        if (c_active) begin
            n_recent = c_win;
            n_pos    = c_pos1;
            n_pse    = c_pse_new;
        end
        if (c_hit) begin
            n_found = 1'b1;
        end
        if (c_emit) begin
            n_ranges = r_ranges + 8'd1;
        end
        if (c_line_hit) begin
            n_nas = c_emit ? c_pos1 : NAS_BLOCK;
        end
        // Entry done: back to the cleared state
        if (c_verdict) begin
            for (int k = 0; k < MAX_QUERY; k++) begin
                n_recent[k] = '0;
            end
            n_pos    = '0;
            n_nas    = '0;
            n_ranges = '0;
            n_found  = 1'b0;
            n_pse    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_QUERY; k++) begin
                r_recent[k] <= '0;
            end
            r_pos    <= '0;
            r_nas    <= '0;
            r_ranges <= '0;
            r_found  <= 1'b0;
            r_pse    <= 1'b1;
        end else begin
            r_recent <= n_recent;
            r_pos    <= n_pos;
            r_nas    <= n_nas;
            r_ranges <= n_ranges;
            r_found  <= n_found;
            r_pse    <= n_pse;
        end
    end

`ifndef ASSERT_OFF
    // A range goes out only while the per-entry budget has room
    a_range_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.v0 && (o_push.beat0.result_kind == spm_pkg::KIND_RANGE))
            |-> (r_ranges < i_cfg.range_cap))
        else $error("range emitted past the per-entry range cap");

    // A verdict leaves the entry state cleared
    a_verdict_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_verdict |=> (r_pos == '0) && r_pse && !r_found && (r_ranges == '0))
        else $error("entry state not cleared after verdict");

    // Byte position saturates at the entry bound
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= ENTRY_LIM)
        else $error("byte position beyond entry bound");
`endif

endmodule

`default_nettype wire

// ===== rtl/spm_outq.sv =====
// Small result queue: up to two beats in, one beat out per cycle while the receiver is ready.
`default_nettype none

module spm_outq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spm_pkg::t_push i_push,
    output logic               o_room,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output spm_pkg::t_out_beat o_out_data
);

    localparam int DEPTH = spm_pkg::OUTQ_DEPTH;
    localparam int PTRW  = spm_pkg::OUTQ_PTR_W;
    localparam int CNTW  = spm_pkg::OUTQ_CNT_W;

    spm_pkg::t_out_beat r_mem [DEPTH];
    logic [PTRW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]    r_count,  n_count;
    logic               c_pop;
    logic [CNTW-1:0]    c_npush;

    // Room for a full two-beat push, judged on the registered count
    assign o_room      = (r_count <= CNTW'(DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign c_pop       = o_out_valid && i_out_ready;
    assign c_npush     = CNTW'(i_push.v0) + CNTW'(i_push.v1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTRW'(c_npush);
        n_rd_ptr = r_rd_ptr + PTRW'(c_pop);
        n_count  = r_count + c_npush - CNTW'(c_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Beat storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.beat0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + PTRW'(1)] <= i_push.beat1;
        end
    end

`ifndef ASSERT_OFF
    // Second beat only rides along with a first
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second push beat without first");

    // Producer honors the room flag
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> (r_count <= CNTW'(DEPTH - 2)))
        else $error("push into queue without room");

    // Occupancy follows pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) +
            CNTW'($past(i_push.v0)) + CNTW'($past(i_push.v1)) - CNTW'($past(c_pop))))
        else $error("queue count mismatch");
`endif

endmodule

`default_nettype wire

// ===== tb/substring_and_prefix_matcher_tb.sv =====
// Self-checking testbench for the substring and prefix matcher: byte stream in, ranges and verdicts out.
`timescale 1ns / 1ps

module substring_and_prefix_matcher_tb;

    localparam int ENTRY_BOUND    = 4096;
    localparam int RANDOM_BEATS   = 520;
    localparam int PHASE_BEATS    = 110;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 1000;

    // DUT connections; the inputs are known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    spm_pkg::t_in_beat    in_data   = '0;
    logic                 in_ready;
    logic                 out_valid;
    spm_pkg::t_out_beat   out_data;
    logic                 out_ready = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [spm_pkg::PADDR_W-1:0]    paddr  = '0;
    logic [spm_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [spm_pkg::CFG_DATA_W-1:0] prdata;
    logic                 pready;

    // Register mirror, reset values
    logic [63:0] cfg_lo   = '0;
    logic [63:0] cfg_hi   = '0;
    logic [4:0]  cfg_len  = '0;
    logic        cfg_mode = spm_pkg::MODE_LINE;
    logic [7:0]  cfg_max  = spm_pkg::MAX_RANGES_RST;

    // Per-entry matcher state kept by the predictor
    logic [7:0]  hist [16];
    int          ent_pos;
    int          resume_pos;
    int          ranges_out;
    logic        entry_hit;
    logic        prefix_ok;

    // Beats waiting to be sent, and reports still owed by the block
    spm_pkg::t_in_beat  entry_beats_todo [$];
    spm_pkg::t_out_beat match_reports_due [$];
    logic [7:0]         entry_text [$];

    // Bookkeeping
    int beats_queued   = 0;
    int beats_accepted = 0;
    int errors         = 0;
    int ranges_seen    = 0;
    int verdicts_seen  = 0;
    int matched_seen   = 0;
    int reg_writes     = 0;
    int quiet_cycles   = 0;
    logic in_taken     = 1'b0;

    // Sender burst shaping and receiver stall pattern
    int          burst_left = 0;
    int          gap_left   = 0;
    logic [15:0] stall_pat  = '1;
    int          stall_left = 0;

    substring_and_prefix_matcher dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_ready(out_ready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] query_char(input int k);
        logic [127:0] q;
        q = {cfg_hi, cfg_lo};
        return q[8 * (k & 15) +: 8];
    endfunction

    function automatic logic [127:0] text_query(input string s);
        logic [127:0] q;
        q = '0;
        for (int k = 0; k < s.len() && k < 16; k++) begin
            q[8 * k +: 8] = s[k];
        end
        return q;
    endfunction

    // Work out the reports one accepted beat should produce
    task automatic predict_match_reports(input spm_pkg::t_in_beat b);
        spm_pkg::t_out_beat res [2];
        int   n;
        int   len;
        int   p;
        int   start;
        logic same;
        n   = 0;
        len = (cfg_len > 5'd16) ? 16 : int'(cfg_len);
        if (!b.entry_empty && ent_pos < ENTRY_BOUND) begin
            p = ent_pos;
            for (int k = 15; k > 0; k--) begin
                hist[k] = hist[k - 1];
            end
            hist[0] = b.entry_byte;
            ent_pos = p + 1;
            if (p < len && b.entry_byte != query_char(p)) begin
                prefix_ok = 1'b0;
            end
            if (len != 0) begin
                if (cfg_mode == spm_pkg::MODE_LINE) begin
                    if (p + 1 >= len) begin
                        same  = 1'b1;
                        start = p + 1 - len;
                        for (int k = 0; k < len; k++) begin
                            if (hist[len - 1 - k] != query_char(k)) same = 1'b0;
                        end
                        if (same && start >= resume_pos) begin
                            entry_hit = 1'b1;
                            if (ranges_out < int'(cfg_max)) begin
                                res[n] = '0;
                                res[n].result_kind = spm_pkg::KIND_RANGE;
                                res[n].range_start = spm_pkg::POS_W'(start);
                                res[n].range_end   = spm_pkg::POS_W'(p + 1);
                                n++;
                                ranges_out++;
                                resume_pos = p + 1;
                            end else begin
                                // cap reached: block any later occurrence
                                resume_pos = ENTRY_BOUND + 1;
                            end
                        end
                    end
                end else if (p + 1 == len && prefix_ok) begin
                    entry_hit = 1'b1;
                    if (ranges_out < int'(cfg_max)) begin
                        res[n] = '0;
                        res[n].result_kind = spm_pkg::KIND_RANGE;
                        res[n].range_end   = spm_pkg::POS_W'(len);
                        n++;
                        ranges_out++;
                    end
                end
            end
        end
        // Verdict closes the entry and clears its state
        if (b.entry_empty || b.end_of_entry) begin
            res[n] = '0;
            res[n].result_kind   = spm_pkg::KIND_VERDICT;
            res[n].entry_matched = (len == 0) || entry_hit;
            n++;
            for (int k = 0; k < 16; k++) hist[k] = '0;
            ent_pos    = 0;
            resume_pos = 0;
            ranges_out = 0;
            entry_hit  = 1'b0;
            prefix_ok  = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            res[k].last_of_run = (k == n - 1);
            match_reports_due = {match_reports_due, res[k]};
        end
    endtask

    task automatic queue_beat(input logic [7:0] b, input logic last, input logic empty);
        spm_pkg::t_in_beat x;
        x.entry_byte   = b;
        x.end_of_entry = last;
        x.entry_empty  = empty;
        entry_beats_todo = {entry_beats_todo, x};
        beats_queued++;
    endtask

    task automatic queue_text(input string s, input logic close);
        for (int k = 0; k < s.len(); k++) begin
            queue_beat(s[k], close && (k == s.len() - 1), 1'b0);
        end
    endtask

    // One entry of random content, mostly built around the current query
    task automatic queue_random_entry(input logic leave_open);
        int   qlen;
        int   span;
        int   r;
        int   idx;
        logic cut_short;
        qlen = (cfg_len > 5'd16) ? 16 : int'(cfg_len);
        r    = $urandom_range(0, 99);
        if (r < 8 && !leave_open) begin
            queue_beat(8'($urandom), 1'($urandom), 1'b1);
            return;
        end
        span = $urandom_range(1, 2 * qlen + 6);
        entry_text = {};
        while (entry_text.size() < span) begin
            r = $urandom_range(0, 99);
            if (qlen != 0 && (r < 35 || (entry_text.size() == 0 && r < 60))) begin
                for (int k = 0; k < qlen; k++) entry_text = {entry_text, query_char(k)};
                // near miss: corrupt one byte of the copy
                if (r < 8) begin
                    idx = entry_text.size() - 1 - $urandom_range(0, qlen - 1);
                    entry_text[idx] = entry_text[idx] ^ 8'($urandom_range(1, 255));
                end
            end else if (qlen != 0 && r < 75) begin
                entry_text = {entry_text, query_char($urandom_range(0, qlen - 1))};
            end else begin
                entry_text = {entry_text, 8'($urandom)};
            end
        end
        cut_short = ($urandom_range(0, 99) < 10) && !leave_open;
        for (int k = 0; k < entry_text.size(); k++) begin
            queue_beat(entry_text[k],
                       !leave_open && !cut_short && (k == entry_text.size() - 1), 1'b0);
        end
        if (cut_short) begin
            queue_beat(8'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    // Wait until every beat is in and every report is out, then let the pipe drain
    task automatic wait_idle();
        while (beats_accepted != beats_queued || match_reports_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [spm_pkg::REG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            spm_pkg::REG_QUERY_LO:  cfg_lo   = val;
            spm_pkg::REG_QUERY_HI:  cfg_hi   = val;
            spm_pkg::REG_QUERY_LEN: cfg_len  = val[4:0];
            spm_pkg::REG_MODE:      cfg_mode = val[0];
            spm_pkg::REG_MAX_RNG:   cfg_max  = val[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(input logic [127:0] q, input int len, input logic mode,
                             input logic [7:0] max_rng);
        wait_idle();
        write_reg(spm_pkg::REG_QUERY_LO, q[63:0]);
        write_reg(spm_pkg::REG_QUERY_HI, q[127:64]);
        write_reg(spm_pkg::REG_QUERY_LEN, 64'(len));
        write_reg(spm_pkg::REG_MODE, {63'd0, mode});
        write_reg(spm_pkg::REG_MAX_RNG, {56'd0, max_rng});
        @(posedge clk);
    endtask

    task automatic random_config();
        logic [127:0] q;
        int           len;
        logic [7:0]   max_rng;
        for (int k = 0; k < 16; k++) begin
            q[8 * k +: 8] = ($urandom_range(0, 99) < 60) ? 8'(8'h61 + $urandom_range(0, 1))
                                                         : 8'($urandom);
        end
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = 16;
            2:       len = 1;
            3:       len = $urandom_range(17, 31);
            4:       len = $urandom_range(7, 15);
            default: len = $urandom_range(2, 6);
        endcase
        case ($urandom_range(0, 7))
            0:       max_rng = 8'd0;
            1:       max_rng = 8'd1;
            2:       max_rng = 8'd2;
            3:       max_rng = 8'd255;
            default: max_rng = 8'($urandom_range(0, 255));
        endcase
        configure(q, len,
                  ($urandom_range(0, 1) == 1) ? spm_pkg::MODE_PREFIX : spm_pkg::MODE_LINE,
                  max_rng);
    endtask

    // Input driver: bursts of beats separated by random gaps
    always @(negedge clk) begin : drive_entry_beats
        logic              nxt_valid;
        spm_pkg::t_in_beat nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (!in_valid || in_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (entry_beats_todo.size() != 0) begin
                nxt_data  = entry_beats_todo.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 99) < 15) begin
                    burst_left = $urandom_range(40, 80);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // Result receiver: rotating stall pattern, reloaded with a random choice when its countdown runs out
    always @(negedge clk) begin : drive_report_ready
        if (stall_left == 0) begin
            stall_left = 48;
            case ($urandom_range(0, 3))
                0:       stall_pat = '1;
                1:       stall_pat = 16'($urandom);
                2:       stall_pat = 16'($urandom & $urandom);
                default: stall_pat = 16'($urandom | $urandom);
            endcase
            stall_pat[0] = 1'b1;
        end
        stall_left--;
        out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
    end

    // Monitor: check reports, predict from accepted beats, watch for a hang
    always @(posedge clk) begin : watch_ports
        spm_pkg::t_out_beat want;
        if (rst_n) begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready) begin
                if (out_data.result_kind == spm_pkg::KIND_VERDICT) begin
                    verdicts_seen++;
                    if (out_data.entry_matched) matched_seen++;
                end else begin
                    ranges_seen++;
                end
                if (match_reports_due.size() == 0) begin
                    $error("report beat with nothing pending: %h", out_data);
                    errors++;
                end else begin
                    want = match_reports_due.pop_front();
                    if (out_data.result_kind !== want.result_kind) begin
                        $error("result_kind: expected %0d, got %0d",
                               want.result_kind, out_data.result_kind);
                        errors++;
                    end
                    if (out_data.range_start !== want.range_start) begin
                        $error("range_start: expected %0d, got %0d",
                               want.range_start, out_data.range_start);
                        errors++;
                    end
                    if (out_data.range_end !== want.range_end) begin
                        $error("range_end: expected %0d, got %0d",
                               want.range_end, out_data.range_end);
                        errors++;
                    end
                    if (out_data.entry_matched !== want.entry_matched) begin
                        $error("entry_matched: expected %0d, got %0d",
                               want.entry_matched, out_data.entry_matched);
                        errors++;
                    end
                    if (out_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, out_data.last_of_run);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                predict_match_reports(in_data);
                beats_accepted++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles, %0d reports outstanding",
                         quiet_cycles, match_reports_due.size());
                $display("substring_and_prefix_matcher_tb: errors");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin : run_matcher_test
        int random_start;
        int phase_start;
        for (int k = 0; k < 16; k++) hist[k] = '0;
        ent_pos    = 0;
        resume_pos = 0;
        ranges_out = 0;
        entry_hit  = 1'b0;
        prefix_ok  = 1'b1;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset config: empty query matches anything, no ranges
        queue_beat(8'h00, 1'b0, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_beat(8'hA5, 1'b1, 1'b1);

        // Line mode, overlapping occurrences give only the leftmost
        configure(text_query("aba"), 3, spm_pkg::MODE_LINE, 8'd16);
        queue_text("ababa", 1'b1);
        // empty flag mid-entry ends it without the byte
        queue_text("ab", 1'b0);
        queue_beat(8'h61, 1'b0, 1'b1);
        // entry with no bytes and a nonempty query
        queue_beat(8'h00, 1'b0, 1'b1);

        // Zero and one range allowed: still matched past the cap
        configure(text_query("aba"), 3, spm_pkg::MODE_LINE, 8'd0);
        queue_text("aba", 1'b1);
        configure(text_query("aba"), 3, spm_pkg::MODE_LINE, 8'd1);
        queue_text("abaaba", 1'b1);

        // Prefix mode: range and verdict on the same byte, then a miss
        configure(text_query("ab"), 2, spm_pkg::MODE_PREFIX, 8'd16);
        queue_text("ab", 1'b1);
        queue_text("xab", 1'b1);

        // Many occurrences against the largest cap
        configure(text_query("ab"), 2, spm_pkg::MODE_LINE, 8'd255);
        for (int k = 0; k < 300; k++) queue_text("ab", k == 299);

        // Random phases; some leave an entry open across a config change
        random_start = beats_queued;
        while (beats_queued - random_start < RANDOM_BEATS) begin
            random_config();
            phase_start = beats_queued;
            while (beats_queued - phase_start < PHASE_BEATS) queue_random_entry(1'b0);
            if ($urandom_range(0, 3) == 0) queue_random_entry(1'b1);
        end
        queue_beat(8'($urandom), 1'b1, 1'b0);

        wait_idle();
        $display("covered %0d input beats over %0d register writes",
                 beats_accepted, reg_writes);
        $display("checked %0d ranges and %0d verdicts, %0d of them matched",
                 ranges_seen, verdicts_seen, matched_seen);
        if (errors == 0) begin
            $display("substring_and_prefix_matcher_tb: clean");
        end else begin
            $display("substring_and_prefix_matcher_tb: errors");
        end
        $finish;
    end

endmodule
